/* hdl/dqs_pkg.sv */
// ----------------------------------------------------------------------------
// dqs_pkg : deque with search, shared definitions
// Sizes, operation and status codes, item structs and ring index helpers.
// ----------------------------------------------------------------------------
package dqs_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int ECNT_W  = 7;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] operand_value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     found;
    logic [STAT_W-1:0]        status;
    logic [ECNT_W-1:0]        entry_count;
  } result_t;

  // base < DEPTH and off <= DEPTH, so one conditional subtract wraps it
  function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] slot_before(input logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] r;
    if (base == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = base - 1'b1;
    end
    return r;
  endfunction

endpackage

/* hdl/dqs_store.sv */
// ----------------------------------------------------------------------------
// dqs_store : entry memory
// DEPTH x 32 array, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dqs_store (
  input  logic                              clk,
  input  logic                              we,
  input  logic [dqs_pkg::IDX_W-1:0]         waddr,
  input  logic signed [dqs_pkg::DATA_W-1:0] wdata,
  input  logic [dqs_pkg::IDX_W-1:0]         raddr,
  output logic signed [dqs_pkg::DATA_W-1:0] rdata
);

  logic signed [dqs_pkg::DATA_W-1:0] mem [dqs_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/double_ended_queue_with_search_top.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_top : bounded deque of signed 32-bit values
// Ring buffer with front index and count; push/pop at either end, and a
// front-to-back search that reports whether a value is held.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload            | notes
//  ---------+---------------------+--------------------+---------------------
//  command  | start in, busy out  | cmd    (cmd_t)     | taken when start & !busy
//  result   | done out (strobe)   | result (result_t)  | valid for one cycle only
//
//  Push, full push, empty pop/search, spare opcode: result in the cycle after the item.
//  Pop: busy in S_POP while the read port returns the entry, then the result.
//  Search: one entry a cycle through the read port and shared comparator, in S_SCAN,
//  front to back; the first hit or the last entry held ends it.
//  Reset (rst, synchronous) empties the queue; memory contents are not cleared.
//  The receiver cannot stall: each result is gone after its strobe cycle.
//
module double_ended_queue_with_search_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dqs_pkg::cmd_t    cmd,
  output logic             done,
  output dqs_pkg::result_t result
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state;

  // queue state
  logic [dqs_pkg::IDX_W-1:0] front;
  logic [dqs_pkg::CNT_W-1:0] count;

  // search sequencer
  logic signed [dqs_pkg::DATA_W-1:0] key;
  logic [dqs_pkg::IDX_W-1:0]         scan_slot;   // slot read this cycle
  logic [dqs_pkg::CNT_W-1:0]         scan_left;   // entries after the one arriving

  // memory port
  logic                              mem_we;
  logic [dqs_pkg::IDX_W-1:0]         mem_waddr;
  logic [dqs_pkg::IDX_W-1:0]         mem_raddr;
  logic signed [dqs_pkg::DATA_W-1:0] mem_rdata;

  logic                      accept;
  logic                      is_full;
  logic                      ring_empty;
  logic                      hit;
  logic [dqs_pkg::IDX_W-1:0] front_prev;
  logic [dqs_pkg::IDX_W-1:0] front_next;
  logic [dqs_pkg::IDX_W-1:0] back_slot;
  logic [dqs_pkg::IDX_W-1:0] last_slot;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign is_full    = (count == dqs_pkg::CNT_W'(dqs_pkg::DEPTH));
  assign ring_empty = (count == '0);

  assign front_prev = dqs_pkg::slot_before(front);
  assign front_next = dqs_pkg::slot_after(front, dqs_pkg::CNT_W'(1));
  assign back_slot  = dqs_pkg::slot_after(front, count);
  assign last_slot  = dqs_pkg::slot_after(front, count - 1'b1);

  // the one shared comparator
  assign hit = (mem_rdata == key);

  // write port: pushes only, from idle
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = back_slot;
    if (accept && !is_full) begin
      case (cmd.opcode)
        dqs_pkg::OP_PUSH_FRONT: begin
          mem_we    = 1'b1;
          mem_waddr = front_prev;
        end
        dqs_pkg::OP_PUSH_BACK: begin
          mem_we    = 1'b1;
          mem_waddr = back_slot;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // read port: pop target or first entry when idle, next entry while scanning
  always_comb begin
    mem_raddr = front;
    if (state == S_SCAN) begin
      mem_raddr = scan_slot;
    end else if (cmd.opcode == dqs_pkg::OP_POP_BACK) begin
      mem_raddr = last_slot;
    end
  end

  dqs_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (cmd.operand_value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.opcode)
              dqs_pkg::OP_PUSH_FRONT: begin
                done <= 1'b1;
                if (!is_full) begin
                  front <= front_prev;
                  count <= count + 1'b1;
                end
              end
              dqs_pkg::OP_PUSH_BACK: begin
                done <= 1'b1;
                if (!is_full) begin
                  count <= count + 1'b1;
                end
              end
              dqs_pkg::OP_POP_FRONT: begin
                if (ring_empty) begin
                  done <= 1'b1;
                end else begin
                  front <= front_next;
                  count <= count - 1'b1;
                  state <= S_POP;
                end
              end
              dqs_pkg::OP_POP_BACK: begin
                if (ring_empty) begin
                  done <= 1'b1;
                end else begin
                  count <= count - 1'b1;
                  state <= S_POP;
                end
              end
              dqs_pkg::OP_SEARCH: begin
                if (ring_empty) begin
                  done <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_POP: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (hit || scan_left == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // search bookkeeping and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          key                 <= cmd.operand_value;
          scan_slot           <= front_next;
          scan_left           <= count - 1'b1;
          result.popped_value <= '0;
          result.found        <= 1'b0;
          result.status       <= dqs_pkg::ST_OK;
          result.entry_count  <= dqs_pkg::ECNT_W'(count);
          case (cmd.opcode)
            dqs_pkg::OP_PUSH_FRONT, dqs_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                result.status <= dqs_pkg::ST_FULL;
              end else begin
                result.entry_count <= dqs_pkg::ECNT_W'(count + 1'b1);
              end
            end
            dqs_pkg::OP_POP_FRONT, dqs_pkg::OP_POP_BACK: begin
              if (ring_empty) begin
                result.status <= dqs_pkg::ST_EMPTY;
              end else begin
                result.entry_count <= dqs_pkg::ECNT_W'(count - 1'b1);
              end
            end
            dqs_pkg::OP_SEARCH: begin
              if (ring_empty) begin
                result.status <= dqs_pkg::ST_EMPTY;
              end
            end
            default: begin
              result.status <= dqs_pkg::ST_OK;
            end
          endcase
        end
      end
      S_POP: begin
        result.popped_value <= mem_rdata;
      end
      S_SCAN: begin
        result.found <= hit;
        scan_slot    <= dqs_pkg::slot_after(scan_slot, dqs_pkg::CNT_W'(1));
        scan_left    <= scan_left - 1'b1;
      end
      default: begin
        result.found <= 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------

  // a result is only ever shown with the sequencer back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe outside idle");

  // every item taken either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("item taken without result or busy");

  // count never exceeds the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dqs_pkg::CNT_W'(dqs_pkg::DEPTH))
    else $error("held count beyond depth");

  // a dropped push only happens on a full ring
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == dqs_pkg::ST_FULL) |->
      result.entry_count == dqs_pkg::ECNT_W'(dqs_pkg::DEPTH))
    else $error("full status with room left");

endmodule

/* dv/tb_double_ended_queue_with_search_top.sv */
// ----------------------------------------------------------------------------
// tb_double_ended_queue_with_search_top : self-checking bench for the deque
// Drives push/pop/search items through the start/busy handshake. A mirror of
// the ring buffer predicts every result, and each done strobe is checked
// field by field against the oldest prediction. A directed opening is
// followed by random fill/drain/mixed stretches under varying sender idling.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_with_search_top;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE_TICKS = dqs_pkg::DEPTH + 16; // longest search plus margin
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned PHASE_COUNT  = 4;

  localparam logic signed [dqs_pkg::DATA_W-1:0] VAL_MAX = {1'b0, {(dqs_pkg::DATA_W-1){1'b1}}};
  localparam logic signed [dqs_pkg::DATA_W-1:0] VAL_MIN = {1'b1, {(dqs_pkg::DATA_W-1){1'b0}}};
  localparam logic signed [dqs_pkg::DATA_W-1:0] VAL_ONES = '1;
  localparam logic signed [dqs_pkg::DATA_W-1:0] VAL_ZERO = '0;

  // Random stretches lean one way so that both full and empty get reached often
  typedef enum {FILL, DRAIN, MIXED} stretch_t;

  // --------------------------------------------------------------------------
  // Deque mirror: own copy of the ring, predicts each result and checks the
  // results in order of issue.
  // --------------------------------------------------------------------------
  class deque_mirror_t;
    logic signed [dqs_pkg::DATA_W-1:0] slots [dqs_pkg::DEPTH];
    int unsigned       head;
    int unsigned       held;
    dqs_pkg::result_t  awaited [$];
    int unsigned       mismatches;

    function new();
      head       = 0;
      held       = 0;
      mismatches = 0;
    endfunction

    function int unsigned ring(int unsigned base, int unsigned off);
      return (base + off) % dqs_pkg::DEPTH;
    endfunction

    function dqs_pkg::result_t predict(dqs_pkg::cmd_t c);
      dqs_pkg::result_t r;
      r.popped_value = '0;
      r.found        = 1'b0;
      r.status       = dqs_pkg::ST_OK;
      case (c.opcode)
        dqs_pkg::OP_PUSH_FRONT: begin
          if (held >= dqs_pkg::DEPTH) begin
            r.status = dqs_pkg::ST_FULL;
          end else begin
            head        = ring(head, dqs_pkg::DEPTH - 1);
            slots[head] = c.operand_value;
            held++;
          end
        end
        dqs_pkg::OP_PUSH_BACK: begin
          if (held >= dqs_pkg::DEPTH) begin
            r.status = dqs_pkg::ST_FULL;
          end else begin
            slots[ring(head, held)] = c.operand_value;
            held++;
          end
        end
        dqs_pkg::OP_POP_FRONT: begin
          if (held == 0) begin
            r.status = dqs_pkg::ST_EMPTY;
          end else begin
            r.popped_value = slots[head];
            head           = ring(head, 1);
            held--;
          end
        end
        dqs_pkg::OP_POP_BACK: begin
          if (held == 0) begin
            r.status = dqs_pkg::ST_EMPTY;
          end else begin
            r.popped_value = slots[ring(head, held - 1)];
            held--;
          end
        end
        dqs_pkg::OP_SEARCH: begin
          if (held == 0) begin
            r.status = dqs_pkg::ST_EMPTY;
          end else begin
            for (int k = 0; k < held; k++) begin
              if (slots[ring(head, k)] == c.operand_value) begin
                r.found = 1'b1;
                break;
              end
            end
          end
        end
        default: begin
        end
      endcase
      r.entry_count = dqs_pkg::ECNT_W'(held);
      return r;
    endfunction

    function void note_cmd(dqs_pkg::cmd_t c);
      awaited.push_back(predict(c));
    endfunction

    task report(string what);
      mismatches++;
      $display("mismatch: %s", what);
    endtask

    task check_result(dqs_pkg::result_t got);
      dqs_pkg::result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing awaited: pop %0d found %0b st %0d cnt %0d",
                         got.popped_value, got.found, got.status, got.entry_count));
        return;
      end
      want = awaited.pop_front();
      if (got.popped_value !== want.popped_value) begin
        report($sformatf("popped_value %0d, predicted %0d",
                         got.popped_value, want.popped_value));
      end
      if (got.found !== want.found) begin
        report($sformatf("found %b, predicted %b", got.found, want.found));
      end
      if (got.status !== want.status) begin
        report($sformatf("status %0d, predicted %0d", got.status, want.status));
      end
      if (got.entry_count !== want.entry_count) begin
        report($sformatf("entry_count %0d, predicted %0d",
                         got.entry_count, want.entry_count));
      end
    endtask

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    // a value currently held, so that searches hit at every depth
    function logic signed [dqs_pkg::DATA_W-1:0] sample_held();
      if (held == 0) begin
        return $urandom;
      end
      return slots[ring(head, $urandom_range(held - 1))];
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself
  // --------------------------------------------------------------------------
  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  dqs_pkg::cmd_t    cmd   = '0;
  logic             busy;
  logic             done;
  dqs_pkg::result_t result;

  deque_mirror_t mirror = new();
  int unsigned idle_pct    = 0;   // chance in a hundred that the sender idles a cycle
  int unsigned cycle_count = 0;
  stretch_t    stretch     = MIXED;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  double_ended_queue_with_search_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  // Results: the block moves its outputs on the rising edge only, so the
  // falling edge sees the value that the next rising edge will take.
  always @(negedge clk) begin
    if (!rst && done === 1'b1) begin
      mirror.check_result(result);
    end
  end

  // Watchdog: ends the run if the handshake or the results stop coming
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offers one item and returns at the rising edge that takes it. Idle cycles
  // go in front of the item; start stays high between back-to-back items, so
  // it is only ever assigned once per edge.
  task automatic issue(dqs_pkg::cmd_t c);
    logic held_off;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    // busy seen at the falling edge is what the next rising edge samples
    do begin
      @(negedge clk);
      held_off = busy;
      @(posedge clk);
    end while (held_off !== 1'b0);
    mirror.note_cmd(c);
  endtask

  task automatic send(logic [dqs_pkg::OP_W-1:0] op, logic signed [dqs_pkg::DATA_W-1:0] val);
    dqs_pkg::cmd_t c;
    c.opcode        = op;
    c.operand_value = val;
    issue(c);
  endtask

  // Sender stands back until every predicted result has arrived
  task automatic quiesce();
    start <= 1'b0;
    while (mirror.outstanding() != 0) begin
      @(posedge clk);
    end
  endtask

  // Mostly wide random values, with extremes and a narrow band for duplicates
  function automatic logic signed [dqs_pkg::DATA_W-1:0] pick_operand();
    logic signed [dqs_pkg::DATA_W-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       v = VAL_MAX;
          1:       v = VAL_MIN;
          2:       v = VAL_ZERO;
          default: v = VAL_ONES;
        endcase
      end
      1, 2:    v = dqs_pkg::DATA_W'($urandom_range(15));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Directed opening: empty-queue corners, spare opcodes, extremes of the
  // operand, search hits at front, middle and back, and a miss.
  // --------------------------------------------------------------------------
  task automatic run_directed();
    send(dqs_pkg::OP_POP_FRONT, VAL_ZERO);           // pop on empty
    send(dqs_pkg::OP_POP_BACK,  VAL_ONES);
    send(dqs_pkg::OP_SEARCH,    VAL_ONES);           // search on empty
    for (int k = int'(dqs_pkg::OP_SEARCH) + 1; k < 2 ** dqs_pkg::OP_W; k++) begin
      send(dqs_pkg::OP_W'(k), $urandom);             // spare opcodes change nothing
    end
    send(dqs_pkg::OP_PUSH_FRONT, VAL_MAX);
    send(dqs_pkg::OP_PUSH_BACK,  VAL_MIN);
    send(dqs_pkg::OP_PUSH_FRONT, VAL_ZERO);
    send(dqs_pkg::OP_PUSH_BACK,  VAL_ONES);          // held: 0, max, min, -1
    send(dqs_pkg::OP_SEARCH,     VAL_ZERO);          // hit at the front
    send(dqs_pkg::OP_SEARCH,     VAL_MIN);           // hit in the middle
    send(dqs_pkg::OP_SEARCH,     VAL_ONES);          // hit at the back, full walk
    send(dqs_pkg::OP_SEARCH,     dqs_pkg::DATA_W'(1)); // miss
    send(dqs_pkg::OP_W'(2 ** dqs_pkg::OP_W - 1), VAL_MAX); // spare opcode with entries held
    send(dqs_pkg::OP_POP_FRONT,  VAL_MAX);
    send(dqs_pkg::OP_POP_BACK,   VAL_MAX);
    send(dqs_pkg::OP_POP_BACK,   VAL_MAX);
    send(dqs_pkg::OP_POP_FRONT,  VAL_MAX);
    send(dqs_pkg::OP_POP_FRONT,  VAL_MAX);           // empty again
    send(dqs_pkg::OP_PUSH_BACK,  32'h5555_5555);
    send(dqs_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA);
    send(dqs_pkg::OP_SEARCH,     32'hAAAA_AAAA);
    send(dqs_pkg::OP_POP_BACK,   VAL_ZERO);
    send(dqs_pkg::OP_POP_BACK,   VAL_ZERO);
  endtask

  // --------------------------------------------------------------------------
  // Random part: stretches that fill towards full (and beyond, for dropped
  // pushes), drain towards empty, or mix. Spare opcodes are sprinkled in as
  // noise and are not counted.
  // --------------------------------------------------------------------------
  task automatic run_random(int unsigned count);
    int unsigned   issued;
    int unsigned   left_in_stretch;
    int unsigned   roll;
    int unsigned   push_w;
    int unsigned   pop_w;
    dqs_pkg::cmd_t c;
    issued          = 0;
    left_in_stretch = 0;
    while (issued < count) begin
      if (left_in_stretch == 0) begin
        case (stretch)
          FILL:    stretch = DRAIN;
          DRAIN:   stretch = MIXED;
          default: stretch = FILL;
        endcase
        left_in_stretch = $urandom_range(160, 100);
      end
      case (stretch)
        FILL:    begin push_w = 80; pop_w = 8;  end
        DRAIN:   begin push_w = 8;  pop_w = 80; end
        default: begin push_w = 35; pop_w = 35; end
      endcase
      if ($urandom_range(99) < 3) begin
        c.opcode        = dqs_pkg::OP_W'($urandom_range(2 ** dqs_pkg::OP_W - 1,
                                                        int'(dqs_pkg::OP_SEARCH) + 1));
        c.operand_value = $urandom;
        issue(c);
      end else begin
        roll = $urandom_range(99);
        if (roll < push_w) begin
          c.opcode        = $urandom_range(1) ? dqs_pkg::OP_PUSH_BACK : dqs_pkg::OP_PUSH_FRONT;
          c.operand_value = pick_operand();
        end else if (roll < push_w + pop_w) begin
          c.opcode        = $urandom_range(1) ? dqs_pkg::OP_POP_BACK : dqs_pkg::OP_POP_FRONT;
          c.operand_value = $urandom;     // ignored, but toggled anyway
        end else begin
          c.opcode        = dqs_pkg::OP_SEARCH;
          c.operand_value = $urandom_range(1) ? mirror.sample_held() : pick_operand();
        end
        issue(c);
        issued++;
        left_in_stretch--;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Run: reset once, directed items, then phases of sender idling with a
  // full pause between phases, then settle and give the verdict.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_idle [PHASE_COUNT];
    phase_idle[0] = 0;    // back to back
    phase_idle[1] = 66;   // sparse items
    phase_idle[2] = 8;    // occasional gaps
    phase_idle[3] = 0;    // back to back again
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    quiesce();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      idle_pct = phase_idle[p];
      run_random(RANDOM_ITEMS / PHASE_COUNT);
      quiesce();
    end

    // late or stray strobes still get caught by the checker
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* double_ended_queue_with_search_top.f */
hdl/dqs_pkg.sv
hdl/dqs_store.sv
hdl/double_ended_queue_with_search_top.sv
dv/tb_double_ended_queue_with_search_top.sv
